// File: design/b64d_pkg.sv
// Shared types, constants and the character classifier of the base64 decoder.
// Used by the front and back stages, the top level and the testbench.
package b64d_pkg;

  localparam int unsigned QDepth = 2;

  localparam logic [2:0] RES_EMPTY = 3'd0;
  localparam logic [2:0] RES_SIX   = 3'd6;
  localparam logic [2:0] RES_FOUR  = 3'd4;
  localparam logic [2:0] RES_TWO   = 3'd2;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;

  localparam logic [1:0] CNT_SAT = 2'd3;

  typedef struct packed {
    logic       hit;
    logic [5:0] value;
  } sextet_t;

  typedef struct packed {
    logic [5:0] sextet;
    logic       is_pad;
    logic       is_bad;
    logic       last;
    logic       url;
  } class_item_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } queue_ctl_t;

  function automatic sextet_t sextet_of(input logic [7:0] c, input logic url);
    sextet_t s;
    s.hit   = 1'b1;
    s.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == CHAR_PLUS || (url && c == CHAR_DASH)) begin
      s.value = 6'd62;
    end else if (c == CHAR_SLASH || (url && c == CHAR_UNDER)) begin
      s.value = 6'd63;
    end else begin
      s.hit = 1'b0;
    end
    return s;
  endfunction

endpackage

// File: design/b64d_if.sv
// Valid/ready channel interfaces for the base64 decoder.
// Character input channel and decoded result channel; no dependencies.
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       message_end;
  logic       bad_input;

  modport source (output valid, output data_byte, output byte_valid,
                  output message_end, output bad_input, input ready);
  modport sink (input valid, input data_byte, input byte_valid,
                input message_end, input bad_input, output ready);
endinterface

// File: design/b64d_front.sv
// Front stage: alphabet register, character classification and a two-entry queue.
// Depends on b64d_pkg and b64d_in_if.
module b64d_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  b64d_in_if.sink              in_ch,
  input  logic                 q_pop,
  output logic                 q_valid,
  output b64d_pkg::class_item_t q_item
);
  import b64d_pkg::*;

  logic        url_r, url_nxt;
  class_item_t mem_r [QDepth];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  class_item_t item_in;
  sextet_t     sx;

  assign in_ch.ready = (count_r != 2'(QDepth));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != 2'd0);
  assign q_item      = mem_r[rd_ptr_r];

  always_comb begin
    sx             = sextet_of(in_ch.char_code, url_r);
    item_in.sextet = sx.value;
    item_in.is_pad = (in_ch.char_code == CHAR_PAD);
    item_in.is_bad = !sx.hit && (in_ch.char_code != CHAR_PAD);
    item_in.last   = in_ch.last_char;
    item_in.url    = url_r;
  end

  always_comb begin
    url_nxt    = cfg_we ? cfg_wdata : url_r;
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = 2'(count_r + {1'b0, push} - {1'b0, q_pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      url_r    <= 1'b0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      url_r    <= url_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// File: design/b64d_back.sv
// Back stage: message state, residue assembly and the result register.
// Depends on b64d_pkg and b64d_out_if.
module b64d_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  b64d_pkg::class_item_t q_item,
  output b64d_pkg::queue_ctl_t  q_ctl,
  b64d_out_if.source            out_ch
);
  import b64d_pkg::*;

  logic [5:0] res_bits_r, res_bits_nxt;
  logic [2:0] res_cnt_r, res_cnt_nxt;
  logic [1:0] len_r, len_nxt;
  logic [1:0] pad_r, pad_nxt;
  logic [1:0] cap_r, cap_nxt;
  logic       err_r, err_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] data_r, data_nxt;
  logic       bvalid_r, bvalid_nxt;
  logic       mend_r, mend_nxt;
  logic       bad_r, bad_nxt;
  logic       pop;

  assign pop         = q_valid && (!out_valid_r || out_ch.ready);
  assign q_ctl.valid = q_valid;
  assign q_ctl.pop   = pop;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_byte   = data_r;
  assign out_ch.byte_valid  = bvalid_r;
  assign out_ch.message_end = mend_r;
  assign out_ch.bad_input   = bad_r;

  always_comb begin
    logic       err1;
    logic       err2;
    logic       have_byte;
    logic       bad;
    logic [7:0] byte_v;
    logic [5:0] v;
    v            = q_item.sextet;
    have_byte    = 1'b0;
    byte_v       = 8'd0;
    res_bits_nxt = res_bits_r;
    res_cnt_nxt  = res_cnt_r;
    pad_nxt      = pad_r;
    cap_nxt      = cap_r;
    len_nxt      = 2'(len_r + 2'd1);
    err1         = err_r || (pad_r != 2'd0 && cap_r != 2'd0);
    if (q_item.is_pad) begin
      err2 = err1 || q_item.url;
      if (pad_r != 2'd0 && cap_r != CNT_SAT) begin
        cap_nxt = 2'(cap_r + 2'd1);
      end
      if (pad_r != CNT_SAT) begin
        pad_nxt = 2'(pad_r + 2'd1);
      end
    end else begin
      err2 = err1 || (pad_r != 2'd0) || q_item.is_bad;
      if (pad_r != 2'd0 && cap_r != CNT_SAT) begin
        cap_nxt = 2'(cap_r + 2'd1);
      end
      if (!err2) begin
        unique case (res_cnt_r)
          RES_SIX: begin
            byte_v       = {res_bits_r, v[5:4]};
            res_bits_nxt = {2'b00, v[3:0]};
            res_cnt_nxt  = RES_FOUR;
            have_byte    = 1'b1;
          end
          RES_FOUR: begin
            byte_v       = {res_bits_r[3:0], v[5:2]};
            res_bits_nxt = {4'b0000, v[1:0]};
            res_cnt_nxt  = RES_TWO;
            have_byte    = 1'b1;
          end
          RES_TWO: begin
            byte_v       = {res_bits_r[1:0], v};
            res_bits_nxt = 6'd0;
            res_cnt_nxt  = RES_EMPTY;
            have_byte    = 1'b1;
          end
          default: begin
            res_bits_nxt = v;
            res_cnt_nxt  = RES_SIX;
          end
        endcase
      end
    end
    err_nxt = err2;
    bad     = err2 || (!q_item.url && len_nxt != 2'd0);

    out_valid_nxt = out_valid_r && !out_ch.ready;
    data_nxt      = data_r;
    bvalid_nxt    = bvalid_r;
    mend_nxt      = mend_r;
    bad_nxt       = bad_r;

    if (!pop) begin
      res_bits_nxt = res_bits_r;
      res_cnt_nxt  = res_cnt_r;
      len_nxt      = len_r;
      pad_nxt      = pad_r;
      cap_nxt      = cap_r;
      err_nxt      = err_r;
    end else if (q_item.last) begin
      out_valid_nxt = 1'b1;
      bvalid_nxt    = have_byte && !bad;
      data_nxt      = (have_byte && !bad) ? byte_v : 8'd0;
      mend_nxt      = 1'b1;
      bad_nxt       = bad;
      res_bits_nxt  = 6'd0;
      res_cnt_nxt   = RES_EMPTY;
      len_nxt       = 2'd0;
      pad_nxt       = 2'd0;
      cap_nxt       = 2'd0;
      err_nxt       = 1'b0;
    end else if (have_byte) begin
      out_valid_nxt = 1'b1;
      bvalid_nxt    = 1'b1;
      data_nxt      = byte_v;
      mend_nxt      = 1'b0;
      bad_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_bits_r  <= 6'd0;
      res_cnt_r   <= RES_EMPTY;
      len_r       <= 2'd0;
      pad_r       <= 2'd0;
      cap_r       <= 2'd0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      res_bits_r  <= res_bits_nxt;
      res_cnt_r   <= res_cnt_nxt;
      len_r       <= len_nxt;
      pad_r       <= pad_nxt;
      cap_r       <= cap_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r   <= data_nxt;
    bvalid_r <= bvalid_nxt;
    mend_r   <= mend_nxt;
    bad_r    <= bad_nxt;
  end

endmodule

// File: design/base64_decoder.sv
// Streaming base64 decoder, standard or URL-safe alphabet, one character per transaction.
// Path: an accepted character is written into the front-stage queue, then popped into the
// result register once it is empty or being taken; two queued characters stall the input.
// Throughput: one character per cycle while out_ch.ready does not stall the result register.
// Reset: synchronous active-low rst_n selects the standard alphabet, clears message state,
// and empties the queue and the result register. Depends on b64d_pkg, b64d_if, front, back.
module base64_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  b64d_in_if.sink    in_ch,
  b64d_out_if.source out_ch
);
  import b64d_pkg::*;

  logic        q_valid;
  class_item_t q_item;
  queue_ctl_t  q_ctl;

  b64d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_pop     (q_ctl.pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  b64d_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ctl   (q_ctl),
    .out_ch  (out_ch)
  );

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_ctl.pop |-> q_ctl.valid)
    else $error("Queue popped while empty.");

  a_mid_result_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.message_end |-> out_ch.byte_valid && !out_ch.bad_input)
    else $error("Result without message end carries no byte.");

  a_bad_has_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.bad_input |-> !out_ch.byte_valid && out_ch.message_end)
    else $error("Bad message result carries a byte.");

endmodule

// File: tb/sv/base64_decoder_tb.sv
// Self-checking testbench for the streaming base64 decoder, standard and URL-safe modes.
// Drives characters through b64d_in_if, checks each decoded byte and message verdict from
// b64d_out_if against an in-bench decoder. Depends on b64d_pkg, b64d_if and base64_decoder.
module base64_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;

  localparam logic MODE_STANDARD = 1'b0;
  localparam logic MODE_URL = 1'b1;
  localparam int unsigned HoldCycles = 200;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
    logic       bad_input;
  } decoded_t;

  typedef logic [7:0] char_q_t[$];

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic tx_valid = 1'b0;
  logic [7:0] tx_char = 8'h00;
  logic tx_last = 1'b0;
  logic rx_ready = 1'b0;

  b64d_in_if char_ch ();
  b64d_out_if byte_ch ();

  assign char_ch.valid = tx_valid;
  assign char_ch.char_code = tx_char;
  assign char_ch.last_char = tx_last;
  assign byte_ch.ready = rx_ready;

  base64_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (char_ch),
    .out_ch   (byte_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  decoded_t pending_decodes[$];
  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int unsigned hold_left = 0;

  logic       mode_url = MODE_STANDARD;
  logic [5:0] acc_bits = '0;
  logic [2:0] acc_count = RES_EMPTY;
  logic [1:0] char_phase = '0;
  logic [1:0] pads = '0;
  logic [1:0] post_pad = '0;
  logic       msg_bad = 1'b0;

  function automatic void decode_char(input logic [7:0] c, input logic last);
    logic [5:0] sx;
    logic hit;
    logic have;
    logic [7:0] byte_out;
    decoded_t res;
    hit = 1'b1;
    sx = '0;
    have = 1'b0;
    byte_out = '0;
    if (c >= "A" && c <= "Z") begin
      sx = 6'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      sx = 6'(c - "a" + 8'd26);
    end else if (c >= "0" && c <= "9") begin
      sx = 6'(c - "0" + 8'd52);
    end else if (c == CHAR_PLUS || (mode_url && c == CHAR_DASH)) begin
      sx = 6'd62;
    end else if (c == CHAR_SLASH || (mode_url && c == CHAR_UNDER)) begin
      sx = 6'd63;
    end else begin
      hit = 1'b0;
    end
    if (pads != 0 && post_pad != 0) msg_bad = 1'b1;
    if (c == CHAR_PAD) begin
      if (mode_url) msg_bad = 1'b1;
      if (pads != 0 && post_pad != CNT_SAT) post_pad = post_pad + 2'd1;
      if (pads != CNT_SAT) pads = pads + 2'd1;
    end else begin
      if (pads != 0) begin
        msg_bad = 1'b1;
        if (post_pad != CNT_SAT) post_pad = post_pad + 2'd1;
      end
      if (!hit) begin
        msg_bad = 1'b1;
      end else if (!msg_bad) begin
        case (acc_count)
          RES_SIX: begin
            byte_out = {acc_bits, sx[5:4]};
            acc_bits = {2'b00, sx[3:0]};
            acc_count = RES_FOUR;
            have = 1'b1;
          end
          RES_FOUR: begin
            byte_out = {acc_bits[3:0], sx[5:2]};
            acc_bits = {4'b0000, sx[1:0]};
            acc_count = RES_TWO;
            have = 1'b1;
          end
          RES_TWO: begin
            byte_out = {acc_bits[1:0], sx};
            acc_bits = '0;
            acc_count = RES_EMPTY;
            have = 1'b1;
          end
          default: begin
            acc_bits = sx;
            acc_count = RES_SIX;
          end
        endcase
      end
    end
    char_phase = char_phase + 2'd1;
    if (last) begin
      if (mode_url == MODE_STANDARD && char_phase != 0) msg_bad = 1'b1;
      res.byte_valid = have && !msg_bad;
      res.data_byte = res.byte_valid ? byte_out : 8'h00;
      res.message_end = 1'b1;
      res.bad_input = msg_bad;
      pending_decodes.insert(pending_decodes.size(), res);
      acc_bits = '0;
      acc_count = RES_EMPTY;
      char_phase = '0;
      pads = '0;
      post_pad = '0;
      msg_bad = 1'b0;
    end else if (have && !msg_bad) begin
      res = '{data_byte: byte_out, byte_valid: 1'b1, message_end: 1'b0, bad_input: 1'b0};
      pending_decodes.insert(pending_decodes.size(), res);
    end
  endfunction

  function automatic void compare_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    decoded_t got;
    decoded_t want;
    if (rst_n && byte_ch.valid && byte_ch.ready) begin
      got = '{data_byte: byte_ch.data_byte, byte_valid: byte_ch.byte_valid,
              message_end: byte_ch.message_end, bad_input: byte_ch.bad_input};
      if (pending_decodes.size() == 0) begin
        $display("%0t: result expected none, actual %p", $time, got);
        mismatches++;
      end else begin
        want = pending_decodes.pop_front();
        compare_field("data_byte", want.data_byte, got.data_byte);
        compare_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
        compare_field("message_end", 8'(want.message_end), 8'(got.message_end));
        compare_field("bad_input", 8'(want.bad_input), 8'(got.bad_input));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HoldCycles;
      rx_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rx_ready <= 1'b0;
    end else begin
      rx_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      tx_valid <= 1'b0;
      @(posedge clk);
    end
    tx_valid <= 1'b1;
    tx_char <= c;
    tx_last <= last;
    do @(posedge clk); while (!char_ch.ready);
    decode_char(c, last);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_message(input char_q_t msg);
    for (int i = 0; i < msg.size(); i++) send_char(msg[i], i == msg.size() - 1);
  endtask

  task automatic wait_drained();
    tx_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic url);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= url;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_url = url;
  endtask

  function automatic logic [7:0] b64_char(input logic [5:0] v, input logic url_form);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return (url_form && $urandom_range(1) == 1) ? CHAR_DASH : CHAR_PLUS;
    return (url_form && $urandom_range(1) == 1) ? CHAR_UNDER : CHAR_SLASH;
  endfunction

  task automatic encode_bytes(input int unsigned nbytes, input logic url_form,
                              output char_q_t msg);
    logic [23:0] grp;
    int unsigned k;
    msg = {};
    for (int unsigned i = 0; i < nbytes; i += 3) begin
      k = (nbytes - i > 3) ? 3 : nbytes - i;
      grp = {8'($urandom), (k > 1) ? 8'($urandom) : 8'h00, (k > 2) ? 8'($urandom) : 8'h00};
      msg.insert(msg.size(), b64_char(grp[23:18], url_form));
      msg.insert(msg.size(), b64_char(grp[17:12], url_form));
      if (k > 1) msg.insert(msg.size(), b64_char(grp[11:6], url_form));
      else if (!url_form) msg.insert(msg.size(), CHAR_PAD);
      if (k > 2) msg.insert(msg.size(), b64_char(grp[5:0], url_form));
      else if (!url_form) msg.insert(msg.size(), CHAR_PAD);
    end
  endtask

  task automatic run_random_segment(input int unsigned n_chars);
    char_q_t msg;
    int unsigned sent;
    int unsigned pick;
    int unsigned pos;
    sent = 0;
    while (sent < n_chars) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        msg = {};
        repeat ($urandom_range(1, 6)) msg.insert(msg.size(), 8'($urandom_range(255)));
      end else begin
        encode_bytes($urandom_range(1, 9), mode_url ^ ($urandom_range(9) == 0), msg);
        if (pick < 25) begin
          pos = $urandom_range(msg.size() - 1);
          case ($urandom_range(3))
            0: msg[pos] = 8'($urandom_range(255));
            1: if (msg.size() > 1) msg.delete(pos);
            2: msg.insert(pos, CHAR_PAD);
            default: msg.insert(pos, 8'($urandom_range(255)));
          endcase
        end
      end
      send_message(msg);
      sent += msg.size();
    end
  endtask

  task automatic test_standard_alphabet();
    set_mode(MODE_STANDARD);
    send_text("TWE=");
    send_text("+/9z");
    send_text("TQ=A");
    send_text("TWE");
    send_text("TW!");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_url_alphabet();
    set_mode(MODE_URL);
    send_text("-_8");
    send_text("A=");
    send_text("Q");
  endtask

  task automatic test_mode_switch();
    set_mode(MODE_STANDARD);
    send_char("Q", 1'b0);
    send_char("U", 1'b0);
    set_mode(MODE_URL);
    send_char("-", 1'b1);
    send_char("Q", 1'b0);
    send_char("_", 1'b0);
    set_mode(MODE_STANDARD);
    send_char("A", 1'b0);
    send_char("A", 1'b1);
  endtask

  task automatic test_receiver_hold();
    wait_drained();
    idle_pct = 0;
    stall_pct <= 0;
    hold_token <= hold_token + 1;
    run_random_segment(40);
  endtask

  task automatic test_random_traffic();
    int unsigned idle_mix[4] = '{0, 51, 0, 19};
    int unsigned stall_mix[4] = '{0, 0, 51, 19};
    for (int p = 0; p < 4; p++) begin
      for (int m = 0; m < 2; m++) begin
        set_mode(m == 0 ? MODE_STANDARD : MODE_URL);
        idle_pct = idle_mix[p];
        stall_pct <= stall_mix[p];
        run_random_segment(160);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_standard_alphabet();
    test_url_alphabet();
    test_mode_switch();
    test_receiver_hold();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
